[hw/rtl/gpc_pkg.sv]
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared types, register indexes and mode codes for the glyph pixel
// compositor.
// ----------------------------------------------------------------------------
package gpc_pkg;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FG_COLOR     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_COLOR     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RENDER_MODE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_KIND   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOLID_CUTOFF = 3'd4;

   // Register reset values
   localparam logic [31:0] FG_COLOR_RST     = 32'hFFFF_FFFF;
   localparam logic [31:0] BG_COLOR_RST     = 32'h0000_00FF;
   localparam logic [7:0]  SOLID_CUTOFF_RST = 8'd128;

   // Channel limits
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

   typedef enum logic [1:0] {
      MODE_SOLID   = 2'd0,
      MODE_SHADED  = 2'd1,
      MODE_BLENDED = 2'd2,
      MODE_ALPHA   = 2'd3
   } mode_type;

   typedef enum logic {
      KIND_COVERAGE8 = 1'b0,
      KIND_MONO      = 1'b1
   } kind_type;

   typedef struct packed {
      logic [7:0]  coverage;
      logic [31:0] dest_pixel;
      logic        inside_req;
   } req_type;

   typedef struct packed {
      logic        write_enable;
      logic [31:0] pixel_out;
   } rsp_type;

   typedef struct packed {
      logic [31:0] fg_color;
      logic [31:0] bg_color;
      mode_type    render_mode;
      kind_type    glyph_kind;
      logic [7:0]  solid_cutoff;
   } cfg_type;

   // After setup: blend operands, alpha forced opaque for direct writes
   typedef struct packed {
      logic        write_enable;
      logic [31:0] src;
      logic [31:0] dst;
      logic [7:0]  alpha;
   } setup_type;

   // After the channel multiplies
   typedef struct packed {
      logic        write_enable;
      logic        pass_src;
      logic        pass_dst;
      logic [31:0] src;
      logic [31:0] dst;
      logic [7:0]  step_g;
      logic [7:0]  step_b;
      logic [7:0]  step_a;
   } mix_type;

endpackage

[hw/rtl/gpc_csr.sv]
// ----------------------------------------------------------------------------
// gpc_csr
// Configuration registers, written one beat at a time from the csr port.
// ----------------------------------------------------------------------------
module gpc_csr
   import gpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   // Always take a write beat
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the index and update one register; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_color     <= FG_COLOR_RST;
         cfg_ff.bg_color     <= BG_COLOR_RST;
         cfg_ff.render_mode  <= MODE_SOLID;
         cfg_ff.glyph_kind   <= KIND_COVERAGE8;
         cfg_ff.solid_cutoff <= SOLID_CUTOFF_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FG_COLOR:     cfg_ff.fg_color     <= csr_wdata;
            CSR_BG_COLOR:     cfg_ff.bg_color     <= csr_wdata;
            CSR_RENDER_MODE:  cfg_ff.render_mode  <= mode_type'(csr_wdata[1:0]);
            CSR_GLYPH_KIND:   cfg_ff.glyph_kind   <= kind_type'(csr_wdata[0]);
            CSR_SOLID_CUTOFF: cfg_ff.solid_cutoff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

endmodule

[hw/rtl/gpc_setup.sv]
// ----------------------------------------------------------------------------
// gpc_setup
// First stage: decide the write and pick blend source, destination and alpha.
// Direct writes travel as source with opaque alpha.
// ----------------------------------------------------------------------------
module gpc_setup
   import gpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   output logic      in_ready,
   input  req_type   in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output setup_type out_data
);

   logic        valid_ff;
   setup_type   data_ff;
   setup_type   data_in;
   logic        hit;
   logic [15:0] cov_scaled;
   logic [7:0]  lerp_alpha;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Scale coverage by foreground alpha for blended mode
   assign cov_scaled = in_data.coverage * cfg.fg_color[7:0];
   assign lerp_alpha = (cfg.fg_color[7:0] == ALPHA_OPAQUE) ? in_data.coverage
                                                           : cov_scaled[15:8];

   assign hit = in_data.inside_req && (in_data.coverage != 8'd0);

   // Select operands per mode
   always_comb begin
      data_in.write_enable = 1'b0;
      data_in.src          = 32'd0;
      data_in.dst          = 32'd0;
      data_in.alpha        = ALPHA_OPAQUE;
      if (hit) begin
         if (cfg.glyph_kind == KIND_MONO) begin
            data_in.write_enable = 1'b1;
            data_in.src          = cfg.fg_color;
         end else begin
            case (cfg.render_mode)
               MODE_SOLID: begin
                  if (in_data.coverage >= cfg.solid_cutoff) begin
                     data_in.write_enable = 1'b1;
                     data_in.src          = cfg.fg_color;
                  end
               end
               MODE_SHADED: begin
                  data_in.write_enable = 1'b1;
                  data_in.src          = {cfg.fg_color[31:8], ALPHA_OPAQUE};
                  data_in.dst          = cfg.bg_color;
                  data_in.alpha        = in_data.coverage;
               end
               MODE_BLENDED: begin
                  data_in.write_enable = 1'b1;
                  data_in.src          = cfg.fg_color;
                  data_in.dst          = in_data.dest_pixel;
                  data_in.alpha        = lerp_alpha;
               end
               default: begin
                  data_in.write_enable = 1'b1;
                  data_in.src          = {cfg.fg_color[31:8], in_data.coverage};
               end
            endcase
         end
      end
   end

   // Advance when the next slot is free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/gpc_mix.sv]
// ----------------------------------------------------------------------------
// gpc_mix
// Second stage: per-channel difference times alpha. In 32-bit modular
// arithmetic the red step shifts out entirely, so only green, blue and
// alpha need a product; each keeps bits 15:8 of its signed product.
// ----------------------------------------------------------------------------
module gpc_mix
   import gpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  setup_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output mix_type   out_data
);

   logic               valid_ff;
   mix_type            data_ff;
   mix_type            data_in;
   logic signed [8:0]  diff_g, diff_b, diff_a;
   logic signed [17:0] prod_g, prod_b, prod_a;
   logic signed [8:0]  alpha_s;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign alpha_s = $signed({1'b0, in_data.alpha});

   // Signed channel differences
   assign diff_g = $signed({1'b0, in_data.src[23:16]}) - $signed({1'b0, in_data.dst[23:16]});
   assign diff_b = $signed({1'b0, in_data.src[15:8]})  - $signed({1'b0, in_data.dst[15:8]});
   assign diff_a = $signed({1'b0, in_data.src[7:0]})   - $signed({1'b0, in_data.dst[7:0]});

   assign prod_g = diff_g * alpha_s;
   assign prod_b = diff_b * alpha_s;
   assign prod_a = diff_a * alpha_s;

   always_comb begin
      data_in.write_enable = in_data.write_enable;
      data_in.pass_src     = (in_data.alpha == ALPHA_OPAQUE);
      data_in.pass_dst     = (in_data.alpha == ALPHA_CLEAR);
      data_in.src          = in_data.src;
      data_in.dst          = in_data.dst;
      data_in.step_g       = prod_g[15:8];
      data_in.step_b       = prod_b[15:8];
      data_in.step_a       = prod_a[15:8];
   end

   // Advance when the next slot is free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/gpc_pack.sv]
// ----------------------------------------------------------------------------
// gpc_pack
// Third stage: add the steps to the destination channels, pick the pass
// cases and hold the result beat in the output register.
// ----------------------------------------------------------------------------
module gpc_pack
   import gpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  mix_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic        valid_ff;
   rsp_type     data_ff;
   rsp_type     data_in;
   logic [31:0] lerp_pixel;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Red keeps the destination byte; others wrap within the byte
   assign lerp_pixel = {in_data.dst[31:24],
                        in_data.dst[23:16] + in_data.step_g,
                        in_data.dst[15:8]  + in_data.step_b,
                        in_data.dst[7:0]   + in_data.step_a};

   always_comb begin
      data_in.write_enable = in_data.write_enable;
      if (in_data.pass_src) begin
         data_in.pixel_out = in_data.src;
      end else if (in_data.pass_dst) begin
         data_in.pixel_out = in_data.dst;
      end else begin
         data_in.pixel_out = lerp_pixel;
      end
   end

   // Hold the beat while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/glyph_pixel_compositor.sv]
// Path: an accepted req beat passes the setup, multiply and pack registers to its rsp beat.
// Throughput: one pixel per clock; each stage moves up when the stage after it
// has room, so a stalled rsp holds the pipe without loss or repeat.
// Reset: synchronous, active high; empties the pipe and loads the register
// defaults (white foreground, opaque black background, solid mode, cutoff 128).
// ----------------------------------------------------------------------------
// glyph_pixel_compositor
// Composites one glyph pixel per beat into a frame buffer write decision
// and RRGGBBAA pixel value.
// ----------------------------------------------------------------------------
module glyph_pixel_compositor
   import gpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   cfg_type   cfg;
   logic      setup_ready;
   logic      setup_valid;
   setup_type setup_data;
   logic      mix_ready;
   logic      mix_valid;
   mix_type   mix_data;
   logic      pack_ready;

   gpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gpc_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (setup_ready),
      .in_data   (req_data),
      .out_valid (setup_valid),
      .out_ready (mix_ready),
      .out_data  (setup_data)
   );

   gpc_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (setup_valid),
      .in_ready  (mix_ready),
      .in_data   (setup_data),
      .out_valid (mix_valid),
      .out_ready (pack_ready),
      .out_data  (mix_data)
   );

   gpc_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (pack_ready),
      .in_data   (mix_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_stall = !setup_ready;

endmodule
